// ----- rtl/core/ciaf_pkg.sv -----
// Shared types and constants for the CIDR IP access filter.
package ciaf_pkg;

    // Rule store sizing
    localparam int MAX_RULES = 1024;
    localparam int IDX_W     = $clog2(MAX_RULES);
    localparam int CNT_W     = IDX_W + 1;

    // Command queue sizing (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int OP_W    = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    // Prefix lengths above this never match
    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_CHECK     = 2'd0,
        OP_ADD_DENY  = 2'd1,
        OP_ADD_ALLOW = 2'd2,
        OP_CLEAR     = 2'd3
    } op_e;

    // Decoded command passed from front to back
    typedef struct packed {
        op_e                op;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  mask;
        logic               hit_en;
    } cmd_t;

    // One stored rule: base already masked
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  mask;
        logic               hit_en;
    } rule_t;

    // Result item, allowed in the low bit
    typedef struct packed {
        logic rule_stored;
        logic allowed;
    } result_t;

endpackage

// ----- rtl/core/cidr_ip_access_filter.sv -----
// Top level of the CIDR IP access filter: front, command queue, back.
// Add, clear and a check against empty lists go straight to the finish state; a check
// otherwise scans the deny list, then the allow list, one entry per cycle through each
// rule memory's read port, and ends early on a hit.
// Throughput: one item at a time in the back stage; up to three more wait.
// Reset (aresetn low, synchronous) empties both rule lists and all stages.
module cidr_ip_access_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ciaf_pkg::S_DATA_W-1:0]  s_tdata,  // address[31:0], prefix_length[37:32]
    input  logic [ciaf_pkg::OP_W-1:0]      s_tuser,  // operation[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ciaf_pkg::M_DATA_W-1:0]  m_tdata   // allowed[0], rule_stored[1]
);
    import ciaf_pkg::*;

    logic     front_valid;
    logic     front_ready;
    cmd_t     front_cmd;
    logic     q_valid;
    logic     q_ready;
    cmd_t     q_cmd;
    result_t  result;

    ciaf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    ciaf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    ciaf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {(M_DATA_W - 2)'(0), result};

endmodule

// ----- rtl/core/ciaf_front.sv -----
// Front stage: accepts input transactions and decodes them into commands.
module ciaf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ciaf_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [ciaf_pkg::OP_W-1:0]      s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output ciaf_pkg::cmd_t                 cmd
);
    import ciaf_pkg::*;

    logic                 valid_reg;
    cmd_t                 cmd_reg;
    logic                 accept;
    logic [ADDR_W-1:0]    address;
    logic [PLEN_W-1:0]    plen;
    cmd_t                 decoded;

    // Stage is free when empty or when its command moves on this cycle
    assign s_tready = !valid_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    // Field extraction and prefix mask
    always_comb begin
        address        = s_tdata[ADDR_W-1:0];
        plen           = s_tdata[ADDR_W +: PLEN_W];
        decoded.op     = op_e'(s_tuser);
        decoded.address = address;
        decoded.mask   = ~({ADDR_W{1'b1}} >> plen);
        decoded.hit_en = (plen <= PLEN_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= decoded;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ----- rtl/core/ciaf_queue.sv -----
// Short command queue between the front and back stages.
module ciaf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ciaf_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output ciaf_pkg::cmd_t  out_cmd
);
    import ciaf_pkg::*;

    cmd_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entries_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/ciaf_back.sv -----
// Back stage: rule stores, list scans and the result register.
module ciaf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ciaf_pkg::cmd_t      cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ciaf_pkg::result_t   m_result
);
    import ciaf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DENY,
        ST_ALLOW,
        ST_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);

    state_t             state_reg;
    logic [CNT_W-1:0]   deny_count_reg;
    logic [CNT_W-1:0]   allow_count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               pend_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               allowed_reg;
    logic               stored_reg;
    logic               m_valid_reg;
    result_t            m_result_reg;

    rule_t              deny_mem  [MAX_RULES];
    rule_t              allow_mem [MAX_RULES];
    rule_t              deny_rdata_reg;
    rule_t              allow_rdata_reg;
    rule_t              new_rule;

    logic               pop;
    logic               deny_issue;
    logic               allow_issue;
    logic               deny_hit;
    logic               allow_hit;
    logic               deny_wr;
    logic               allow_wr;
    logic               out_free;

    // Scan control and match logic
    always_comb begin
        cmd_ready   = (state_reg == ST_IDLE);
        pop         = cmd_valid && cmd_ready;
        deny_issue  = (state_reg == ST_DENY) && (idx_reg < deny_count_reg);
        allow_issue = (state_reg == ST_ALLOW) && (idx_reg < allow_count_reg);
        deny_hit    = deny_rdata_reg.hit_en &&
                      ((addr_reg & deny_rdata_reg.mask) == deny_rdata_reg.base);
        allow_hit   = allow_rdata_reg.hit_en &&
                      ((addr_reg & allow_rdata_reg.mask) == allow_rdata_reg.base);
        deny_wr     = pop && (cmd.op == OP_ADD_DENY) && (deny_count_reg < CNT_FULL);
        allow_wr    = pop && (cmd.op == OP_ADD_ALLOW) && (allow_count_reg < CNT_FULL);
        out_free    = !m_valid_reg || m_tready;
        new_rule.base   = cmd.address & cmd.mask;
        new_rule.mask   = cmd.mask;
        new_rule.hit_en = cmd.hit_en;
    end

    // Deny rule store
    always_ff @(posedge aclk) begin
        if (deny_wr) begin
            deny_mem[deny_count_reg[IDX_W-1:0]] <= new_rule;
        end
        if (deny_issue) begin
            deny_rdata_reg <= deny_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Allow rule store
    always_ff @(posedge aclk) begin
        if (allow_wr) begin
            allow_mem[allow_count_reg[IDX_W-1:0]] <= new_rule;
        end
        if (allow_issue) begin
            allow_rdata_reg <= allow_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Sequencer, counts and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            deny_count_reg  <= '0;
            allow_count_reg <= '0;
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            allowed_reg     <= 1'b0;
            stored_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // result valid: load on finish, drop once taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        allowed_reg <= 1'b0;
                        stored_reg  <= 1'b0;
                        idx_reg     <= '0;
                        pend_reg    <= 1'b0;
                        unique case (cmd.op)
                            OP_CHECK: begin
                                addr_reg <= cmd.address;
                                if (deny_count_reg != '0) begin
                                    state_reg <= ST_DENY;
                                end else if (allow_count_reg != '0) begin
                                    state_reg <= ST_ALLOW;
                                end else begin
                                    allowed_reg <= 1'b1;
                                    state_reg   <= ST_FINISH;
                                end
                            end
                            OP_ADD_DENY: begin
                                if (deny_wr) begin
                                    deny_count_reg <= deny_count_reg + 1'b1;
                                    stored_reg     <= 1'b1;
                                end
                                state_reg <= ST_FINISH;
                            end
                            OP_ADD_ALLOW: begin
                                if (allow_wr) begin
                                    allow_count_reg <= allow_count_reg + 1'b1;
                                    stored_reg      <= 1'b1;
                                end
                                state_reg <= ST_FINISH;
                            end
                            OP_CLEAR: begin
                                deny_count_reg  <= '0;
                                allow_count_reg <= '0;
                                state_reg       <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_DENY: begin
                    // read one entry per cycle, compare the previous read
                    if (deny_issue) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    pend_reg <= deny_issue;
                    if (pend_reg && deny_hit) begin
                        allowed_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end else if (!deny_issue && !pend_reg) begin
                        if (allow_count_reg == '0) begin
                            allowed_reg <= 1'b1;
                            state_reg   <= ST_FINISH;
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= ST_ALLOW;
                        end
                    end
                end
                ST_ALLOW: begin
                    if (allow_issue) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    pend_reg <= allow_issue;
                    if (pend_reg && allow_hit) begin
                        allowed_reg <= 1'b1;
                        state_reg   <= ST_FINISH;
                    end else if (!allow_issue && !pend_reg) begin
                        allowed_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_result_reg.allowed     <= allowed_reg;
                        m_result_reg.rule_stored <= stored_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ----- rtl/core/ciaf_checker.sv -----
// Port-level checker for the CIDR IP access filter, bound to the top level.
module ciaf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ciaf_pkg::M_DATA_W-1:0]  m_tdata
);
    import ciaf_pkg::*;

    logic [3:0] outstanding_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // Transactions accepted but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else if (s_fire && !m_fire) begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // A stalled result holds its data
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Never a result without an accepted item behind it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> outstanding_reg != '0)
        else $error("result with no outstanding transaction");

    // Padding is zero and an item never reports both allowed and stored
    a_result_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:2] == '0) && !(m_tdata[0] && m_tdata[1]))
        else $error("malformed result");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cidr_ip_access_filter ciaf_checker u_ciaf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/cidr_filter_checker.sv -----
// Checker for the CIDR IP access filter: predicts each verdict and compares the result stream.
module cidr_filter_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ciaf_pkg::S_DATA_W-1:0]  s_tdata,  // address[31:0], prefix_length[37:32]
    input  logic [ciaf_pkg::OP_W-1:0]      s_tuser,  // operation[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ciaf_pkg::M_DATA_W-1:0]  m_tdata,  // allowed[0], rule_stored[1]
    output int                             fail_count,
    output int                             outstanding,
    output int                             results_checked,
    output int                             adds_dropped
);

    // Shadow copy of both rule lists
    logic [ciaf_pkg::ADDR_W-1:0] deny_base    [ciaf_pkg::MAX_RULES];
    logic [ciaf_pkg::PLEN_W-1:0] deny_plen    [ciaf_pkg::MAX_RULES];
    logic [ciaf_pkg::ADDR_W-1:0] allow_base   [ciaf_pkg::MAX_RULES];
    logic [ciaf_pkg::PLEN_W-1:0] allow_plen   [ciaf_pkg::MAX_RULES];
    int unsigned                 deny_used  = 0;
    int unsigned                 allow_used = 0;

    // Verdicts still owed by the block, oldest first
    ciaf_pkg::result_t verdict_q [$];

    int errors   = 0;
    int compared = 0;
    int drops    = 0;

    // Prefix 0 covers everything; prefixes above 32 cover nothing
    function automatic logic rule_covers(input logic [ciaf_pkg::ADDR_W-1:0] addr,
                                         input logic [ciaf_pkg::ADDR_W-1:0] base,
                                         input logic [ciaf_pkg::PLEN_W-1:0] plen);
        logic [ciaf_pkg::ADDR_W-1:0] mask;
        if (plen > ciaf_pkg::PLEN_MAX) begin
            return 1'b0;
        end
        mask = (plen == '0) ? '0 : (32'hFFFF_FFFF << (32 - int'(plen)));
        return (addr & mask) == (base & mask);
    endfunction

    // Applies one request to the shadow lists and returns the verdict it owes
    function automatic ciaf_pkg::result_t predict_verdict(input ciaf_pkg::op_e op,
                                                          input logic [ciaf_pkg::ADDR_W-1:0] addr,
                                                          input logic [ciaf_pkg::PLEN_W-1:0] plen);
        ciaf_pkg::result_t verdict;
        logic              denied;
        logic              permitted;
        verdict = '0;
        case (op)
            ciaf_pkg::OP_CHECK: begin
                denied = 1'b0;
                for (int unsigned i = 0; i < deny_used; i++) begin
                    if (rule_covers(addr, deny_base[i], deny_plen[i])) begin
                        denied = 1'b1;
                    end
                end
                // empty allow list lets everything through that was not denied
                permitted = (allow_used == 0);
                for (int unsigned i = 0; i < allow_used; i++) begin
                    if (rule_covers(addr, allow_base[i], allow_plen[i])) begin
                        permitted = 1'b1;
                    end
                end
                verdict.allowed = !denied && permitted;
            end
            ciaf_pkg::OP_ADD_DENY: begin
                if (deny_used < ciaf_pkg::MAX_RULES) begin
                    deny_base[deny_used] = addr;
                    deny_plen[deny_used] = plen;
                    deny_used++;
                    verdict.rule_stored = 1'b1;
                end else begin
                    drops++;
                end
            end
            ciaf_pkg::OP_ADD_ALLOW: begin
                if (allow_used < ciaf_pkg::MAX_RULES) begin
                    allow_base[allow_used] = addr;
                    allow_plen[allow_used] = plen;
                    allow_used++;
                    verdict.rule_stored = 1'b1;
                end else begin
                    drops++;
                end
            end
            default: begin
                deny_used  = 0;
                allow_used = 0;
            end
        endcase
        return verdict;
    endfunction

    // Result side first: a result never belongs to a request taken at the same edge
    always @(posedge aclk) begin : watch
        ciaf_pkg::result_t want;
        ciaf_pkg::result_t got;
        if (!aresetn) begin
            deny_used  = 0;
            allow_used = 0;
            verdict_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.allowed     = m_tdata[0];
                got.rule_stored = m_tdata[1];
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual allowed=%0b stored=%0b",
                             $time, got.allowed, got.rule_stored);
                end else begin
                    want = verdict_q.pop_front();
                    compared++;
                    if (got.allowed !== want.allowed) begin
                        errors++;
                        $display("%0t: allowed mismatch, expected %0b, actual %0b",
                                 $time, want.allowed, got.allowed);
                    end
                    if (got.rule_stored !== want.rule_stored) begin
                        errors++;
                        $display("%0t: rule_stored mismatch, expected %0b, actual %0b",
                                 $time, want.rule_stored, got.rule_stored);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(predict_verdict(ciaf_pkg::op_e'(s_tuser),
                                                    s_tdata[ciaf_pkg::ADDR_W-1:0],
                                                    s_tdata[ciaf_pkg::ADDR_W +: ciaf_pkg::PLEN_W]));
            end
        end
        fail_count      <= errors;
        outstanding     <= verdict_q.size();
        results_checked <= compared;
        adds_dropped    <= drops;
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the CIDR IP access filter: clock, reset, request stimulus and verdict.
module tb_top;

    localparam int STALL_LIMIT   = 30000;
    localparam int SETTLE_CYCLES = 2100;
    localparam int PHASE_ITEMS   = 89;
    localparam int PAD_W = ciaf_pkg::S_DATA_W - ciaf_pkg::ADDR_W - ciaf_pkg::PLEN_W;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ciaf_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [ciaf_pkg::OP_W-1:0]     s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ciaf_pkg::M_DATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int results_checked;
    int adds_dropped;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    // Recent rule bases, used to aim checks at or near existing rules
    logic [ciaf_pkg::ADDR_W-1:0] rule_pool [$];

    always #1 aclk = ~aclk;

    cidr_ip_access_filter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cidr_filter_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .adds_dropped    (adds_dropped)
    );

    // Result-side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request transaction, with random idle cycles ahead of it
    task automatic send_request(input ciaf_pkg::op_e op,
                                input logic [ciaf_pkg::ADDR_W-1:0] addr,
                                input logic [ciaf_pkg::PLEN_W-1:0] plen);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, plen, addr};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Hold off requests until every owed verdict has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // A pool entry with a few low bits flipped, mostly inside its prefix
    function automatic logic [ciaf_pkg::ADDR_W-1:0] near_rule();
        int                          k;
        logic [ciaf_pkg::ADDR_W-1:0] flips;
        if (rule_pool.size() == 0) begin
            return $urandom;
        end
        k = ($urandom_range(3, 0) == 0) ? $urandom_range(32, 0) : $urandom_range(8, 0);
        flips = (k == 0) ? '0 : ($urandom >> (32 - k));
        return rule_pool[$urandom_range(rule_pool.size() - 1, 0)] ^ flips;
    endfunction

    // Mostly real prefixes, some match-all and some never-match
    function automatic logic [ciaf_pkg::PLEN_W-1:0] pick_prefix();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 5) begin
            return '0;
        end else if (roll < 17) begin
            return ciaf_pkg::PLEN_W'($urandom_range(63, 33));
        end
        return ciaf_pkg::PLEN_W'($urandom_range(32, 1));
    endfunction

    task automatic random_request();
        int                          roll;
        logic [ciaf_pkg::ADDR_W-1:0] base;
        roll = $urandom_range(99, 0);
        base = ($urandom_range(1, 0) == 1) ? near_rule() : $urandom;
        if (roll < 45) begin
            send_request(ciaf_pkg::OP_CHECK,
                         ($urandom_range(9, 0) < 7) ? near_rule() : $urandom,
                         ciaf_pkg::PLEN_W'($urandom));
        end else if (roll < 93) begin
            rule_pool.push_back(base);
            if (rule_pool.size() > 48) begin
                void'(rule_pool.pop_front());
            end
            send_request((roll < 66) ? ciaf_pkg::OP_ADD_DENY : ciaf_pkg::OP_ADD_ALLOW,
                         base, pick_prefix());
        end else begin
            send_request(ciaf_pkg::OP_CLEAR, $urandom, ciaf_pkg::PLEN_W'($urandom));
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_request();
            if (i == 48) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct  = 14;
        rx_stall_pct <= 63;

        // Directed: empty lists, allow-only, deny over allow, odd prefixes, clear
        send_request(ciaf_pkg::OP_CHECK,     32'h0000_0000, 6'd0);
        send_request(ciaf_pkg::OP_CHECK,     32'hFFFF_FFFF, 6'd63);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'h0A00_0000, 6'd8);
        send_request(ciaf_pkg::OP_CHECK,     32'h0A01_0203, 6'd0);
        send_request(ciaf_pkg::OP_CHECK,     32'h0B00_0001, 6'd0);
        send_request(ciaf_pkg::OP_ADD_DENY,  32'h0A01_0000, 6'd16);
        send_request(ciaf_pkg::OP_CHECK,     32'h0A01_00FF, 6'd0);
        send_request(ciaf_pkg::OP_CHECK,     32'h0A02_0001, 6'd0);
        send_request(ciaf_pkg::OP_ADD_DENY,  32'hC0A8_0101, 6'd32);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'hC0A8_0101, 6'd32);
        send_request(ciaf_pkg::OP_CHECK,     32'hC0A8_0101, 6'd0);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'hC0A8_0000, 6'd33);
        send_request(ciaf_pkg::OP_CHECK,     32'hC0A8_0000, 6'd0);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'hFFFF_FFFF, 6'd63);
        send_request(ciaf_pkg::OP_CLEAR,     32'hFFFF_FFFF, 6'd63);
        send_request(ciaf_pkg::OP_CHECK,     32'h0B00_0001, 6'd0);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'h0000_0000, 6'd40);
        send_request(ciaf_pkg::OP_CHECK,     32'h0000_0000, 6'd0);
        send_request(ciaf_pkg::OP_ADD_ALLOW, 32'h0000_0000, 6'd0);
        send_request(ciaf_pkg::OP_CHECK,     32'hFFFF_FFFF, 6'd0);
        send_request(ciaf_pkg::OP_ADD_DENY,  32'h1234_5678, 6'd0);
        send_request(ciaf_pkg::OP_CHECK,     32'h0A00_0001, 6'd0);
        send_request(ciaf_pkg::OP_ADD_DENY,  32'hFFFF_FFFF, 6'd32);
        send_request(ciaf_pkg::OP_CLEAR,     32'h0000_0000, 6'd0);
        wait_drained();

        // Random traffic under three stall profiles
        random_phase(14, 63);
        random_phase(63, 14);
        random_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d requests: directed cases and random traffic",
                 items_sent);
        $display("under three stall profiles; %0d verdicts compared, %0d adds refused as full.",
                 results_checked, adds_dropped);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
